// ----- rtl/b3sh_pkg.sv -----
// ----------------------------------------------------------------------------
// b3sh_pkg
// Shared constants, types and functions of the streaming BLAKE3 hasher.
// ----------------------------------------------------------------------------
package b3sh_pkg;

   localparam logic [1:0] REQ_DATA     = 2'd0;
   localparam logic [1:0] REQ_FINALIZE = 2'd1;
   localparam logic [1:0] REQ_RESTART  = 2'd2;

   localparam logic [31:0] FLAG_START  = 32'd1;
   localparam logic [31:0] FLAG_END    = 32'd2;
   localparam logic [31:0] FLAG_PARENT = 32'd4;
   localparam logic [31:0] FLAG_ROOT   = 32'd8;

   localparam int BLOCK_BYTES = 64;
   localparam int ROUNDS      = 7;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] state16_type;
   typedef word_type [7:0] cv_type;

   localparam cv_type IV = '{32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                             32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

   // message schedule index for round r, position p
   function automatic logic [3:0] perm_idx(input logic [2:0] r, input logic [3:0] p);
      logic [63:0] row;
      case (r)
         3'd0: row = 64'hFEDCBA9876543210;
         3'd1: row = 64'h8FE95CB1D407A362;
         3'd2: row = 64'h18FB0956E72DCA43;
         3'd3: row = 64'h61852B04FD3E9C7A;
         3'd4: row = 64'h461035278EAFB9DC;
         3'd5: row = 64'h7462A03D1FC85BE9;
         3'd6: row = 64'hD743C2AE689105FB;
         default: row = 64'hFEDCBA9876543210;
      endcase
      return row[p*4 +: 4];
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // quarter-round mixing of four words
   function automatic logic [127:0] g_mix(input word_type a, input word_type b,
                                         input word_type c, input word_type d,
                                         input word_type x, input word_type y);
      word_type a1, b1, c1, d1;
      a1 = a + b + x;
      d1 = rotr(d ^ a1, 16);
      c1 = c + d1;
      b1 = rotr(b ^ c1, 12);
      a1 = a1 + b1 + y;
      d1 = rotr(d1 ^ a1, 8);
      c1 = c1 + d1;
      b1 = rotr(b1 ^ c1, 7);
      return {d1, c1, b1, a1};
   endfunction

endpackage

// ----- rtl/blake3_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// blake3_stream_hasher
// Streaming unkeyed BLAKE3 hash with extendable output, one shared round unit.
// ----------------------------------------------------------------------------
// One round unit applies a half round (four quarter mixes) per cycle, and a
// compression also has a load step and a finish step. A data transaction
// absorbs one byte per cycle, pausing for a compression when a full block
// is pending, and for up to 54 more compressions for subtree merges at a chunk
// end (each merge also reads the stack memory). A finalize runs one
// compression per stack level, then one compression per eight output words;
// each output word is offered on rsp until it is taken. The subtree stack
// is a memory that is never cleared; only entries below the stack count are
// read.
module blake3_stream_hasher
   import b3sh_pkg::*;
#(
   parameter int STACK_LEVELS = 54
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_bytes[63:0], byte_count[67:64], zeros
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // digest_word[63:0]
   output logic        rsp_tlast,   // last_word
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // out_words
);

   localparam int SW = $clog2(STACK_LEVELS + 1);
   localparam int AW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_BYTE    = 4'd1;
   localparam logic [3:0] S_RUN     = 4'd2;
   localparam logic [3:0] S_BLKDONE = 4'd3;
   localparam logic [3:0] S_MRGRD   = 4'd4;
   localparam logic [3:0] S_MRGLD   = 4'd5;
   localparam logic [3:0] S_PUSH    = 4'd6;
   localparam logic [3:0] S_FRD     = 4'd7;
   localparam logic [3:0] S_FLD     = 4'd8;
   localparam logic [3:0] S_OUT     = 4'd9;
   localparam logic [3:0] S_FSTART  = 4'd10;

   // purpose of the running compression
   localparam logic [1:0] P_BLOCK  = 2'd0;
   localparam logic [1:0] P_MERGE  = 2'd1;
   localparam logic [1:0] P_FINAL  = 2'd2;
   localparam logic [1:0] P_ROOT   = 2'd3;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  purp_ff, purp_in;
   logic [6:0]  out_words_ff;
   cv_type      chain_ff, chain_in;
   state16_type blk_ff, blk_in;
   logic [6:0]  fill_ff, fill_in;
   logic [3:0]  done_ff, done_in;
   logic [63:0] cidx_ff, cidx_in;
   logic [SW-1:0] scount_ff, scount_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  nbytes_ff, nbytes_in;
   logic [63:0] total_ff, total_in;
   // compression working set
   state16_type v_ff, v_in;
   state16_type m_ff, m_in;
   cv_type      cvin_ff, cvin_in;
   logic [3:0]  step_ff, step_in;
   // finalize context
   cv_type      fcv_ff, fcv_in;
   state16_type fm_ff, fm_in;
   logic [63:0] fctr_ff, fctr_in;
   logic [31:0] flen_ff, flen_in;
   logic [31:0] fflg_ff, fflg_in;
   logic [SW-1:0] fi_ff, fi_in;
   logic [6:0]  k_ff, k_in;
   logic [6:0]  nw_ff, nw_in;
   state16_type res_ff, res_in;

   // stack memory, one chaining value per entry
   logic [255:0] stack_mem [STACK_LEVELS];
   logic [255:0] rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [255:0]  wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_ff <= stack_mem[rd_addr];
   end

   // half round: columns on even steps, diagonals on odd steps
   state16_type v_rnd;
   always_comb begin
      logic [2:0] r;
      logic [3:0] b;
      logic [127:0] g;
      r = step_ff[3:1];
      b = step_ff[0] ? 4'd8 : 4'd0;
      v_rnd = v_ff;
      if (!step_ff[0]) begin
         for (int i = 0; i < 4; i++) begin
            g = g_mix(v_ff[i], v_ff[i+4], v_ff[i+8], v_ff[i+12],
                      m_ff[perm_idx(r, b + 4'(2*i))], m_ff[perm_idx(r, b + 4'(2*i+1))]);
            v_rnd[i] = g[31:0];     v_rnd[i+4] = g[63:32];
            v_rnd[i+8] = g[95:64];  v_rnd[i+12] = g[127:96];
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            g = g_mix(v_ff[i], v_ff[4 + ((i+1)%4)], v_ff[8 + ((i+2)%4)],
                      v_ff[12 + ((i+3)%4)],
                      m_ff[perm_idx(r, b + 4'(2*i))], m_ff[perm_idx(r, b + 4'(2*i+1))]);
            v_rnd[i] = g[31:0];
            v_rnd[4 + ((i+1)%4)] = g[63:32];
            v_rnd[8 + ((i+2)%4)] = g[95:64];
            v_rnd[12 + ((i+3)%4)] = g[127:96];
         end
      end
   end

   // compression output from finished state
   state16_type cres;
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         cres[i]   = v_ff[i] ^ v_ff[i+8];
         cres[i+8] = v_ff[i+8] ^ cvin_ff[i];
      end
   end

   function automatic state16_type init_v(input cv_type cv, input logic [63:0] ctr,
                                          input logic [31:0] len, input logic [31:0] fl);
      state16_type v;
      for (int i = 0; i < 8; i++) v[i] = cv[i];
      for (int i = 0; i < 4; i++) v[8+i] = IV[i];
      v[12] = ctr[31:0];
      v[13] = ctr[63:32];
      v[14] = len;
      v[15] = fl;
      return v;
   endfunction

   logic req_fire, rsp_fire;
   logic [3:0] bc_sat;
   logic [31:0] start_fl;
   cv_type res_cv;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // the cycle that loads a fresh root block is not offered
   assign rsp_tvalid = (state_ff == S_OUT) && (step_ff != 4'(2*ROUNDS));
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {res_ff[{k_ff[2:0], 1'b1}], res_ff[{k_ff[2:0], 1'b0}]};
   assign rsp_tlast  = (k_ff + 7'd1 == nw_ff);
   assign bc_sat     = (req_tdata[67:64] > 4'd8) ? 4'd8 : req_tdata[67:64];
   assign start_fl   = (done_ff == 4'd0) ? FLAG_START : 32'd0;
   always_comb begin
      for (int i = 0; i < 8; i++) res_cv[i] = cres[i];
   end

   // sequencer
   always_comb begin
      logic [31:0] fl;
      state16_type pm;
      state_in  = state_ff;
      purp_in   = purp_ff;
      chain_in  = chain_ff;
      blk_in    = blk_ff;
      fill_in   = fill_ff;
      done_in   = done_ff;
      cidx_in   = cidx_ff;
      scount_in = scount_ff;
      data_in   = data_ff;
      nbytes_in = nbytes_ff;
      total_in  = total_ff;
      v_in      = v_ff;
      m_in      = m_ff;
      cvin_in   = cvin_ff;
      step_in   = step_ff;
      fcv_in    = fcv_ff;
      fm_in     = fm_ff;
      fctr_in   = fctr_ff;
      flen_in   = flen_ff;
      fflg_in   = fflg_ff;
      fi_in     = fi_ff;
      k_in      = k_ff;
      nw_in     = nw_ff;
      res_in    = res_ff;
      rd_addr   = AW'(scount_ff - SW'(1));
      wr_addr   = AW'(scount_ff);
      wr_en     = 1'b0;
      wr_data   = chain_ff;
      fl        = '0;
      pm        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  REQ_DATA: begin
                     data_in   = req_tdata[63:0];
                     nbytes_in = bc_sat;
                     if (bc_sat != 4'd0) state_in = S_BYTE;
                  end
                  REQ_RESTART: begin
                     chain_in  = IV;
                     blk_in    = '0;
                     fill_in   = '0;
                     done_in   = '0;
                     cidx_in   = '0;
                     scount_in = '0;
                  end
                  REQ_FINALIZE: begin
                     fcv_in  = chain_ff;
                     fm_in   = blk_ff;
                     fctr_in = cidx_ff;
                     flen_in = 32'(fill_ff);
                     fflg_in = start_fl | FLAG_END;
                     fi_in   = (scount_ff > SW'(STACK_LEVELS)) ? SW'(STACK_LEVELS)
                                                                : scount_ff;
                     nw_in   = (out_words_ff == 7'd0) ? 7'd1 :
                               (out_words_ff > 7'd64) ? 7'd64 : out_words_ff;
                     k_in    = '0;
                     state_in = S_FSTART;
                  end
                  default: ;
               endcase
            end
         end
         S_BYTE: begin
            if (fill_ff >= 7'(BLOCK_BYTES)) begin
               // lazy compression of a full block
               fl = start_fl | ((done_ff == 4'd15) ? FLAG_END : 32'd0);
               v_in    = init_v(chain_ff, cidx_ff, 32'(BLOCK_BYTES), fl);
               m_in    = blk_ff;
               cvin_in = chain_ff;
               step_in = '0;
               purp_in = P_BLOCK;
               state_in = S_RUN;
            end else begin
               blk_in[fill_ff[5:2]][fill_ff[1:0]*8 +: 8] = data_ff[7:0];
               fill_in   = fill_ff + 7'd1;
               data_in   = data_ff >> 8;
               nbytes_in = nbytes_ff - 4'd1;
               if (nbytes_ff == 4'd1) state_in = S_IDLE;
            end
         end
         S_RUN: begin
            v_in    = v_rnd;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(2*ROUNDS - 1)) begin
               unique case (purp_ff)
                  P_BLOCK: state_in = S_BLKDONE;
                  P_MERGE: state_in = S_BLKDONE;
                  P_FINAL: state_in = S_FSTART;
                  P_ROOT:  state_in = S_OUT;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_BLKDONE: begin
            if (purp_ff == P_BLOCK) begin
               // in the cycle after the last round, v_ff holds the final state
               blk_in  = '0;
               fill_in = '0;
               if (done_ff == 4'd15) begin
                  chain_in = res_cv;
                  cidx_in  = cidx_ff + 64'd1;
                  total_in = cidx_ff + 64'd1;
                  done_in  = '0;
                  purp_in  = P_MERGE;
                  state_in = S_MRGRD;
               end else begin
                  chain_in = res_cv;
                  done_in  = done_ff + 4'd1;
                  state_in = S_BYTE;
               end
            end else begin
               // parent node done: it replaces the popped entry
               chain_in  = res_cv;
               scount_in = scount_ff - SW'(1);
               total_in  = total_ff >> 1;
               state_in  = S_MRGRD;
            end
         end
         S_MRGRD: begin
            // chain_ff holds the running chunk value during merges
            if (!total_ff[0] && scount_ff != '0) begin
               state_in = S_MRGLD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_MRGLD: begin
            for (int i = 0; i < 8; i++) begin
               pm[i]   = rd_ff[i*32 +: 32];
               pm[i+8] = chain_ff[i];
            end
            v_in    = init_v(IV, 64'd0, 32'(BLOCK_BYTES), FLAG_PARENT);
            m_in    = pm;
            cvin_in = IV;
            step_in = '0;
            purp_in = P_MERGE;
            state_in = S_RUN;
         end
         S_PUSH: begin
            if (scount_ff < SW'(STACK_LEVELS)) begin
               wr_en     = 1'b1;
               scount_in = scount_ff + SW'(1);
            end
            chain_in = IV;
            purp_in  = P_BLOCK;
            state_in = S_BYTE;
         end
         S_FSTART: begin
            if (purp_ff == P_FINAL && step_ff == 4'(2*ROUNDS)) begin
               // fold the finished node into a parent block
               step_in = '0;
               rd_addr = AW'(fi_ff);
               for (int i = 0; i < 8; i++) fm_in[i+8] = cres[i];
               fcv_in   = IV;
               fctr_in  = '0;
               flen_in  = 32'(BLOCK_BYTES);
               fflg_in  = FLAG_PARENT;
               state_in = S_FRD;
            end else if (fi_ff != '0) begin
               fi_in    = fi_ff - SW'(1);
               v_in     = init_v(fcv_ff, fctr_ff, flen_ff, fflg_ff);
               m_in     = fm_ff;
               cvin_in  = fcv_ff;
               step_in  = '0;
               purp_in  = P_FINAL;
               state_in = S_RUN;
            end else begin
               v_in     = init_v(fcv_ff, 64'(k_ff[6:3]), flen_ff, fflg_ff | FLAG_ROOT);
               m_in     = fm_ff;
               cvin_in  = fcv_ff;
               step_in  = '0;
               purp_in  = P_ROOT;
               state_in = S_RUN;
            end
         end
         S_FRD: begin
            rd_addr  = AW'(fi_ff);
            state_in = S_FLD;
         end
         S_FLD: begin
            for (int i = 0; i < 8; i++) fm_in[i] = rd_ff[i*32 +: 32];
            purp_in  = P_BLOCK;
            state_in = S_FSTART;
         end
         S_OUT: begin
            if (step_ff == 4'(2*ROUNDS)) begin
               res_in  = cres;
               step_in = '0;
            end else if (rsp_fire) begin
               k_in = k_ff + 7'd1;
               if (k_ff + 7'd1 == nw_ff) begin
                  purp_in  = P_BLOCK;
                  state_in = S_IDLE;
               end else if (k_in[2:0] == 3'd0) begin
                  state_in = S_FSTART;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         purp_ff      <= P_BLOCK;
         out_words_ff <= 7'd4;
         chain_ff     <= IV;
         blk_ff       <= '0;
         fill_ff      <= '0;
         done_ff      <= '0;
         cidx_ff      <= '0;
         scount_ff    <= '0;
         step_ff      <= '0;
         k_ff         <= '0;
      end else begin
         state_ff  <= state_in;
         purp_ff   <= purp_in;
         chain_ff  <= chain_in;
         blk_ff    <= blk_in;
         fill_ff   <= fill_in;
         done_ff   <= done_in;
         cidx_ff   <= cidx_in;
         scount_ff <= scount_in;
         step_ff   <= step_in;
         k_ff      <= k_in;
         if (csr_valid && csr_ready) out_words_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      nbytes_ff <= nbytes_in;
      total_ff  <= total_in;
      v_ff      <= v_in;
      m_ff      <= m_in;
      cvin_ff   <= cvin_in;
      fcv_ff    <= fcv_in;
      fm_ff     <= fm_in;
      fctr_ff   <= fctr_in;
      flen_ff   <= flen_in;
      fflg_ff   <= fflg_in;
      fi_ff     <= fi_in;
      nw_ff     <= nw_in;
      res_ff    <= res_in;
   end

endmodule

// ----- tb/tb_blake3_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// tb_blake3_stream_hasher
// Self-checking bench: drives message, finalize and restart transactions,
// predicts every digest word with an in-bench BLAKE3 model and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_blake3_stream_hasher;
   import b3sh_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int STACK_DEPTH = 54;
   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE      = 1500;
   localparam int HOLD_CYCLES = 400;

   typedef bit [7:0][31:0]  chain_t;
   typedef bit [15:0][31:0] block_t;

   localparam chain_t CHAIN_IV = {32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                                  32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};
   // message word permutation applied after every round
   localparam bit [15:0][3:0] MSG_PERM = {4'd8, 4'd15, 4'd14, 4'd9, 4'd5, 4'd12, 4'd11, 4'd1,
                                          4'd13, 4'd4, 4'd0, 4'd7, 4'd10, 4'd3, 4'd6, 4'd2};

   // Digest predictor and expected-word store
   class digest_scoreboard;
      chain_t     chain;
      block_t     blk;
      int         fill;
      int         blocks_done;
      bit [63:0]  chunk_no;
      chain_t     stack_cv[STACK_DEPTH];
      int         stack_cnt;
      bit [6:0]   out_words;
      bit [64:0]  digest_q[$];
      int         mismatches;

      function new();
         out_words  = 7'd4;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         chain       = CHAIN_IV;
         blk         = '0;
         fill        = 0;
         blocks_done = 0;
         chunk_no    = '0;
         stack_cnt   = 0;
      endfunction

      function bit [31:0] rotr(bit [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void quarter(inout block_t v, input int a, b, c, d, input bit [31:0] x, y);
         v[a] = v[a] + v[b] + x; v[d] = rotr(v[d] ^ v[a], 16);
         v[c] = v[c] + v[d];     v[b] = rotr(v[b] ^ v[c], 12);
         v[a] = v[a] + v[b] + y; v[d] = rotr(v[d] ^ v[a], 8);
         v[c] = v[c] + v[d];     v[b] = rotr(v[b] ^ v[c], 7);
      endfunction

      function block_t compress(chain_t cv, block_t msg, bit [63:0] ctr, bit [31:0] len,
                                bit [31:0] fl);
         block_t v, m, s, res;
         m = msg;
         for (int i = 0; i < 8; i++) v[i] = cv[i];
         for (int i = 0; i < 4; i++) v[8 + i] = CHAIN_IV[i];
         v[12] = ctr[31:0];
         v[13] = ctr[63:32];
         v[14] = len;
         v[15] = fl;
         for (int r = 0; r < 7; r++) begin
            quarter(v, 0, 4, 8, 12, m[0], m[1]);
            quarter(v, 1, 5, 9, 13, m[2], m[3]);
            quarter(v, 2, 6, 10, 14, m[4], m[5]);
            quarter(v, 3, 7, 11, 15, m[6], m[7]);
            quarter(v, 0, 5, 10, 15, m[8], m[9]);
            quarter(v, 1, 6, 11, 12, m[10], m[11]);
            quarter(v, 2, 7, 8, 13, m[12], m[13]);
            quarter(v, 3, 4, 9, 14, m[14], m[15]);
            s = m;
            for (int i = 0; i < 16; i++) m[i] = s[MSG_PERM[i]];
         end
         for (int i = 0; i < 8; i++) begin
            res[i]     = v[i] ^ v[i + 8];
            res[i + 8] = v[i + 8] ^ cv[i];
         end
         return res;
      endfunction

      function chain_t low_half(block_t b);
         chain_t c;
         for (int i = 0; i < 8; i++) c[i] = b[i];
         return c;
      endfunction

      function block_t join_cv(chain_t l, chain_t r);
         block_t m;
         for (int i = 0; i < 8; i++) begin
            m[i]     = l[i];
            m[i + 8] = r[i];
         end
         return m;
      endfunction

      // finished chunk goes onto the subtree stack, merging while count is even
      function void push_chunk(chain_t cv, bit [63:0] total);
         while (total[0] == 1'b0 && stack_cnt > 0) begin
            cv = low_half(compress(CHAIN_IV, join_cv(stack_cv[stack_cnt - 1], cv), 64'd0,
                                   32'd64, FLAG_PARENT));
            stack_cnt--;
            total = total >> 1;
         end
         if (stack_cnt < STACK_DEPTH) begin
            stack_cv[stack_cnt] = cv;
            stack_cnt++;
         end
      endfunction

      function void absorb(bit [7:0] b);
         block_t    res;
         bit [31:0] fl;
         // a full block is compressed only once the next byte shows up
         if (fill >= 64) begin
            fl = (blocks_done == 0) ? FLAG_START : 32'd0;
            if (blocks_done >= 15) fl |= FLAG_END;
            res = compress(chain, blk, chunk_no, 32'd64, fl);
            if (blocks_done >= 15) begin
               chunk_no++;
               push_chunk(low_half(res), chunk_no);
               chain       = CHAIN_IV;
               blocks_done = 0;
            end else begin
               chain = low_half(res);
               blocks_done++;
            end
            blk  = '0;
            fill = 0;
         end
         blk[fill / 4][(fill % 4) * 8 +: 8] = b;
         fill++;
      endfunction

      function void finalize();
         chain_t    ncv;
         block_t    m, res;
         bit [63:0] ctr;
         bit [31:0] len, fl;
         int        nw;
         ncv = chain;
         m   = blk;
         ctr = chunk_no;
         len = fill;
         fl  = ((blocks_done == 0) ? FLAG_START : 32'd0) | FLAG_END;
         for (int i = stack_cnt - 1; i >= 0; i--) begin
            res = compress(ncv, m, ctr, len, fl);
            m   = join_cv(stack_cv[i], low_half(res));
            ncv = CHAIN_IV;
            ctr = '0;
            len = 32'd64;
            fl  = FLAG_PARENT;
         end
         nw = out_words;
         if (nw == 0) nw = 1;
         if (nw > 64) nw = 64;
         for (int k = 0; k < nw; k++) begin
            if (k % 8 == 0) res = compress(ncv, m, 64'(k / 8), len, fl | FLAG_ROOT);
            digest_q.push_back({(k + 1 == nw), res[2 * (k % 8) + 1], res[2 * (k % 8)]});
         end
      endfunction

      function void note_request(bit [1:0] kind, bit [63:0] bytes, bit [3:0] count);
         int n;
         case (kind)
            REQ_DATA: begin
               n = (count > 8) ? 8 : count;
               for (int i = 0; i < n; i++) absorb(bytes[8 * i +: 8]);
            end
            REQ_FINALIZE: finalize();
            REQ_RESTART:  restart();
            default: ;
         endcase
      endfunction

      function void check_word(bit [63:0] word, bit last);
         bit [64:0] exp_w;
         if (digest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digest word %h last %b", word, last);
            return;
         end
         exp_w = digest_q.pop_front();
         if (exp_w[63:0] !== word || exp_w[64] !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("digest mismatch: expected %h last %b, got %h last %b",
                        exp_w[63:0], exp_w[64], word, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [6:0]  csr_data;

   digest_scoreboard sb;
   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  hold_request;
   int  idle_cycles;

   blake3_stream_hasher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // receiver: random stalls, with an occasional long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[blake3_stream_hasher] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(bit [1:0] kind, bit [63:0] bytes, bit [3:0] count);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'd0, count, bytes};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, bytes, count);
   endtask

   task automatic send_bytes(int count);
      send_request(REQ_DATA, {$urandom, $urandom}, 4'(count));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.digest_q.size() != 0) @(posedge clock);
   endtask

   // register write only once the block has gone quiet
   task automatic write_out_words(bit [6:0] value);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.out_words = value;
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 82)      send_bytes($urandom_range(8, 1));
      else if (pick < 85) send_bytes($urandom_range(15, 9));
      else if (pick < 87) send_bytes(0);
      else if (pick < 95) send_request(REQ_FINALIZE, {$urandom, $urandom}, 4'($urandom));
      else if (pick < 98) send_request(REQ_RESTART, {$urandom, $urandom}, 4'($urandom));
      else                send_request(REQ_UNUSED, {$urandom, $urandom}, 4'($urandom));
   endtask

   task automatic random_phase(int items, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < items; i++) random_request();
      send_request(REQ_FINALIZE, '0, 4'd0);
   endtask

   initial begin
      sb            = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = REQ_DATA;
      csr_valid     = 1'b0;
      csr_data      = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b0;
      idle_cycles   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, extremes, ignored and saturated items
      send_request(REQ_FINALIZE, '0, 4'd0);
      send_request(REQ_DATA, 64'd0, 4'd1);
      send_request(REQ_FINALIZE, '0, 4'd0);
      send_request(REQ_DATA, '1, 4'd8);
      send_request(REQ_DATA, '1, 4'd0);
      send_request(REQ_DATA, 64'h0123456789ABCDEF, 4'd15);
      send_request(REQ_UNUSED, '1, 4'd8);
      send_request(REQ_FINALIZE, '0, 4'd0);
      send_request(REQ_RESTART, '1, 4'd15);
      send_request(REQ_FINALIZE, '0, 4'd0);
      // exactly one block: its compression is deferred to finalize
      for (int i = 0; i < 8; i++) send_bytes(8);
      drain();
      send_request(REQ_FINALIZE, '0, 4'd0);
      send_request(REQ_RESTART, '0, 4'd0);

      // one full chunk, finalized at the chunk edge and again past it
      write_out_words(7'd64);
      send_idle_pct = 51;
      rsp_stall_pct = 51;
      for (int i = 0; i < 128; i++) send_bytes(8);
      send_request(REQ_FINALIZE, '0, 4'd0);
      for (int i = 0; i < 12; i++) send_bytes($urandom_range(8, 1));
      // receiver holds off while finalize transactions keep coming
      send_idle_pct = 0;
      hold_request  = 1'b1;
      for (int i = 0; i < 4; i++) begin
         send_request(REQ_FINALIZE, '0, 4'd0);
         send_bytes(8);
      end

      write_out_words(7'd1);
      random_phase(5, 0, 0);
      write_out_words(7'd0);
      random_phase(5, 51, 0);
      write_out_words(7'd127);
      random_phase(5, 0, 51);
      write_out_words(7'd17);
      random_phase(5, 36, 36);
      send_request(REQ_RESTART, '0, 4'd0);
      random_phase(5, 0, 0);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (sb.mismatches == 0 && sb.digest_q.size() == 0) begin
         $display("[blake3_stream_hasher] OK");
      end else begin
         $display("[blake3_stream_hasher] ERROR");
      end
      $finish;
   end

endmodule
